>>> hdl/spm_pkg.sv
// spm_pkg: shared types, codes and sizes for the stereo peak hold / rms meter
// used by spm_isqrt and stereo_peak_hold_rms_meter; no dependencies
package spm_pkg;

  localparam int LEVEL_BITS   = 16;
  localparam int AGE_BITS     = 16;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int MODE_BITS    = 2;
  localparam int DECAY_FRAC   = 8;

  // shared multiplier operand width: magnitudes, age overshoot and decay rate
  localparam int MUL_W  = (LEVEL_BITS > AGE_BITS) ?
                          ((LEVEL_BITS > CFG_BITS) ? LEVEL_BITS : CFG_BITS) :
                          ((AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS);
  localparam int PROD_W = 2 * MUL_W;
  localparam int RAD_W  = 2 * LEVEL_BITS;
  localparam int CMP_W  = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;

  localparam logic [MODE_BITS-1:0] MODE_LEVEL   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_TICK    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_COLLECT = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR   = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_RATE = 2'd1;

  localparam logic [CFG_BITS-1:0] HOLD_MIN   = 16'd100;
  localparam logic [CFG_BITS-1:0] HOLD_RESET = 16'd1000;
  localparam logic [CFG_BITS-1:0] DECAY_RESET = 16'd256;

  localparam logic [AGE_BITS-1:0]   AGE_MAX    = '1;
  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = LEVEL_BITS'(1) << (LEVEL_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_LEFT,
    ST_SQ_RIGHT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DECAY_MUL,
    ST_DECAY_SUB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]         mode;
    logic signed [LEVEL_BITS-1:0] left_level;
    logic signed [LEVEL_BITS-1:0] right_level;
  } in_item_t;

  typedef struct packed {
    logic                         from_collect;
    logic signed [LEVEL_BITS-1:0] left_out;
    logic signed [LEVEL_BITS-1:0] right_out;
    logic [LEVEL_BITS-1:0]        peak_out;
    logic [LEVEL_BITS-1:0]        rms_out;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

>>> hdl/spm_isqrt.sv
// spm_isqrt: iterative floor square root, one result bit per cycle
// depends on spm_pkg for RAD_W and the status struct
module spm_isqrt
  import spm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RAD_W-1:0] radicand,
  output sqrt_stat_t       stat,
  output logic [RAD_W-1:0] root
);

  localparam logic [RAD_W-1:0] BIT_TOP = RAD_W'(1) << (RAD_W - 2);

  logic [RAD_W-1:0] n_r, n_nxt;
  logic [RAD_W-1:0] root_r, root_nxt;
  logic [RAD_W-1:0] bit_r, bit_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [RAD_W-1:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    n_nxt    = n_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = radicand;
      root_nxt = '0;
      bit_nxt  = BIT_TOP;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_nxt    = n_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      // last step when the trial bit runs off the bottom
      if ((bit_r >> 2) == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r    <= n_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

>>> hdl/stereo_peak_hold_rms_meter.sv
// stereo_peak_hold_rms_meter: stereo level meter with peak hold, decay and rms
// depends on spm_pkg and spm_isqrt
//
// usage:
//   in_valid/in_ready/in_data carry one request: level sample, 1 ms tick,
//   collect or clear. out_valid/out_ready/out_data return one result for a
//   level sample or a collect; ticks and clears give none.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write hold_time_ms (index 0, values
//   below 100 stored as 100) and decay_rate (index 1); other indexes ignored.
//   cfg_ready is always high; write only while the meter is idle.
// sequencing:
//   tick and clear finish without leaving idle. a level sample makes two
//   squaring passes through the shared multiplier, then runs the iterative
//   square root, one bit per cycle, then emits. a collect goes straight to
//   emit, or through multiply and subtract first when decay applies. in_ready
//   stays low while busy.
// reset: synchronous, active low; stores and age clear, registers return to
//   hold 1000 ms and rate 256. a result waits in the output register while
//   out_ready is low, and the meter holds its last step until it drains.
module stereo_peak_hold_rms_meter
  import spm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  state_t state_r, state_nxt;

  logic [CFG_BITS-1:0]          hold_r, hold_nxt;
  logic [CFG_BITS-1:0]          decay_r, decay_nxt;
  logic signed [LEVEL_BITS-1:0] left_r, left_nxt;
  logic signed [LEVEL_BITS-1:0] right_r, right_nxt;
  logic [LEVEL_BITS-1:0]        peak_r, peak_nxt;
  logic [LEVEL_BITS-1:0]        rms_r, rms_nxt;
  logic [AGE_BITS-1:0]          age_r, age_nxt;
  logic [LEVEL_BITS-1:0]        mag_l_r, mag_l_nxt;
  logic [LEVEL_BITS-1:0]        mag_r_r, mag_r_nxt;
  logic [AGE_BITS-1:0]          over_r, over_nxt;
  logic [PROD_W-1:0]            acc_r, acc_nxt;
  logic                         collect_r, collect_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_item_t                    out_data_r, out_data_nxt;

  logic [LEVEL_BITS-1:0] in_mag_l, in_mag_r, in_mag_max;
  logic                  in_fire;
  logic                  decay_hit;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     wide_peak;
  logic                  sqrt_start;
  sqrt_stat_t            sqrt_stat;
  logic [RAD_W-1:0]      sqrt_root;

  spm_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (RAD_W'(acc_r >> 1)),
    .stat     (sqrt_stat),
    .root     (sqrt_root)
  );

  // magnitude of full-scale negative reads as FULL_SCALE in the unsigned result
  assign in_mag_l   = in_data.left_level[LEVEL_BITS-1] ?
                      LEVEL_BITS'(~in_data.left_level + 1'b1) : LEVEL_BITS'(in_data.left_level);
  assign in_mag_r   = in_data.right_level[LEVEL_BITS-1] ?
                      LEVEL_BITS'(~in_data.right_level + 1'b1) : LEVEL_BITS'(in_data.right_level);
  assign in_mag_max = (in_mag_l > in_mag_r) ? in_mag_l : in_mag_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign decay_hit = (CMP_W'(age_r) > CMP_W'(hold_r)) && (peak_r != '0);
  assign wide_peak = PROD_W'(peak_r) << DECAY_FRAC;

  // the one shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ_LEFT: begin
        mul_a = MUL_W'(mag_l_r);
        mul_b = MUL_W'(mag_l_r);
      end
      ST_SQ_RIGHT: begin
        mul_a = MUL_W'(mag_r_r);
        mul_b = MUL_W'(mag_r_r);
      end
      ST_DECAY_MUL: begin
        mul_a = MUL_W'(over_r);
        mul_b = MUL_W'(decay_r);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    state_nxt     = state_r;
    hold_nxt      = hold_r;
    decay_nxt     = decay_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    peak_nxt      = peak_r;
    rms_nxt       = rms_r;
    age_nxt       = age_r;
    mag_l_nxt     = mag_l_r;
    mag_r_nxt     = mag_r_r;
    over_nxt      = over_r;
    acc_nxt       = acc_r;
    collect_nxt   = collect_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sqrt_start    = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (cfg_index)
        REG_HOLD_TIME:  hold_nxt  = (cfg_data < HOLD_MIN) ? HOLD_MIN : cfg_data;
        REG_DECAY_RATE: decay_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.mode)
            MODE_LEVEL: begin
              left_nxt    = in_data.left_level;
              right_nxt   = in_data.right_level;
              mag_l_nxt   = in_mag_l;
              mag_r_nxt   = in_mag_r;
              collect_nxt = 1'b0;
              if (in_mag_max >= peak_r) begin
                peak_nxt = in_mag_max;
                age_nxt  = '0;
              end
              state_nxt = ST_SQ_LEFT;
            end
            MODE_TICK: begin
              if (age_r != AGE_MAX) begin
                age_nxt = age_r + 1'b1;
              end
            end
            MODE_COLLECT: begin
              collect_nxt = 1'b1;
              over_nxt    = AGE_BITS'(CMP_W'(age_r) - CMP_W'(hold_r));
              state_nxt   = decay_hit ? ST_DECAY_MUL : ST_EMIT;
            end
            MODE_CLEAR: begin
              left_nxt  = '0;
              right_nxt = '0;
              peak_nxt  = '0;
              rms_nxt   = '0;
              age_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SQ_LEFT: begin
        acc_nxt   = prod;
        state_nxt = ST_SQ_RIGHT;
      end
      ST_SQ_RIGHT: begin
        acc_nxt   = acc_r + prod;
        state_nxt = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sqrt_stat.done) begin
          rms_nxt   = LEVEL_BITS'(sqrt_root);
          state_nxt = ST_EMIT;
        end
      end
      ST_DECAY_MUL: begin
        acc_nxt   = prod;
        state_nxt = ST_DECAY_SUB;
      end
      ST_DECAY_SUB: begin
        // Q.8 subtract, floored at zero, fraction dropped
        if (wide_peak > acc_r) begin
          peak_nxt = LEVEL_BITS'((wide_peak - acc_r) >> DECAY_FRAC);
        end else begin
          peak_nxt = '0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.from_collect = collect_r;
          out_data_nxt.left_out     = left_r;
          out_data_nxt.right_out    = right_r;
          out_data_nxt.peak_out     = peak_r;
          out_data_nxt.rms_out      = rms_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hold_r      <= HOLD_RESET;
      decay_r     <= DECAY_RESET;
      left_r      <= '0;
      right_r     <= '0;
      peak_r      <= '0;
      rms_r       <= '0;
      age_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_r      <= hold_nxt;
      decay_r     <= decay_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      peak_r      <= peak_nxt;
      rms_r       <= rms_nxt;
      age_r       <= age_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_l_r    <= mag_l_nxt;
    mag_r_r    <= mag_r_nxt;
    over_r     <= over_nxt;
    acc_r      <= acc_nxt;
    collect_r  <= collect_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_stat.done |-> (state_r == ST_ROOT_WAIT))
    else $error("square root finished outside its wait state");

  a_peak_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= FULL_SCALE)
    else $error("held peak above full scale");

  a_rms_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rms_r <= FULL_SCALE)
    else $error("rms above full scale");

  a_level_starts_square: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.mode == MODE_LEVEL)) |=> (state_r == ST_SQ_LEFT))
    else $error("level request did not start the squaring pass");
`endif

endmodule
